@@ rtl/core/sequence_gap_checker_top_assert.svh @@
// Assertion macros for the sequence gap checker.
// Each macro takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef SEQUENCE_GAP_CHECKER_TOP_ASSERT_SVH
`define SEQUENCE_GAP_CHECKER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SGC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sequence gap checker assertion failed");
// Next-cycle implication
`define SGC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sequence gap checker assertion failed");
`else
`define SGC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SGC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/sgc_pkg.sv @@
package sgc_pkg;

	// default width of the sequence index arithmetic
	localparam int INDEX_WIDTH_DEF = 32;

	// wrap register value after reset
	localparam logic [31:0] WRAP_RESET = 32'hFFFF_FFFF;

	// command codes
	localparam logic [2:0] CMD_CHECK  = 3'd0;
	localparam logic [2:0] CMD_INIT   = 3'd1;
	localparam logic [2:0] CMD_RESET  = 3'd2;
	localparam logic [2:0] CMD_DEINIT = 3'd3;
	localparam logic [2:0] CMD_QUERY  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SEQ   = 2'd2;
	localparam logic [1:0] ST_INIT  = 2'd3;

	// one input transaction
	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] index;
	} item_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] gap;
		logic [31:0] missing_total;
		logic        active;
	} result_t;

endpackage

@@ rtl/core/sequence_gap_checker_top.sv @@
// Sequence gap checker: tracks frame sequence numbers that count from 0 up to the wrap
// register and then restart at 0. Every input transaction (check, init, reset, deinit,
// query) gives exactly one result transaction carrying the status, the gap just before
// the last index, the saturating 32-bit missing-frame count and the active flag. An item
// is registered, processed by combinational logic against the held state, and lands in
// the result register, so one transaction per cycle is sustained while the downstream side
// does not stall; an item passes through the input register and then the result register
// before its result is valid. The result register is what limits throughput when the
// downstream side stalls. Write the wrap register only while no transaction is in flight.
module sequence_gap_checker_top #(
	parameter int INDEX_WIDTH = sgc_pkg::INDEX_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	input  logic            item_valid,
	output logic            item_stall,
	input  sgc_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output sgc_pkg::result_t result
);

`include "sequence_gap_checker_top_assert.svh"

	localparam int IW = INDEX_WIDTH;

	logic [31:0]       wrap_q;
	logic [IW-1:0]     last_index_q;
	logic [IW-1:0]     last_gap_q;
	logic [31:0]       missing_q;
	logic              running_q;

	logic              valid_s1;
	sgc_pkg::item_t    item_s1;
	logic              result_valid_q;
	sgc_pkg::result_t  result_q;

	logic              advance;

	logic [63:0]       idx_ext;
	logic [63:0]       wrap_ext;
	logic [IW-1:0]     idx;
	logic [IW-1:0]     wrap;
	logic              wrap_zero;
	logic              idx_over;
	logic [IW-1:0]     delta;
	logic [IW-1:0]     chk_gap;
	logic [63:0]       chk_gap_ext;
	logic [32:0]       miss_sum;
	logic [31:0]       chk_miss;

	logic [IW-1:0]     nxt_last_index;
	logic [IW-1:0]     nxt_last_gap;
	logic [31:0]       nxt_missing;
	logic              nxt_running;
	logic [1:0]        nxt_status;
	logic [63:0]       nxt_gap_ext;

	// wrap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= sgc_pkg::WRAP_RESET;
		end else if (cfg_we) begin
			wrap_q <= cfg_wdata;
		end
	end

	// handshake: stage 1 moves on when the result register is free or draining
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	// index and wrap trimmed to the working width
	assign idx_ext   = 64'(item_s1.index);
	assign wrap_ext  = 64'(wrap_q);
	assign idx       = idx_ext[IW-1:0];
	assign wrap      = wrap_ext[IW-1:0];
	assign wrap_zero = (wrap == '0);
	assign idx_over  = (idx > wrap);

	// modular distance from the last index, and the gap it implies
	always_comb begin
		if (idx > last_index_q) begin
			delta = idx - last_index_q;
		end else begin
			delta = wrap - last_index_q + idx + IW'(1);
		end
		chk_gap = (delta > IW'(1)) ? (delta - IW'(1)) : '0;
	end

	// saturating add into the missing count
	assign chk_gap_ext = 64'(chk_gap);
	assign miss_sum    = {1'b0, missing_q} + {1'b0, chk_gap_ext[31:0]};
	assign chk_miss    = ((|chk_gap_ext[63:32]) || miss_sum[32]) ? 32'hFFFF_FFFF
	                                                             : miss_sum[31:0];

	// command decode and next state
	always_comb begin
		nxt_last_index = last_index_q;
		nxt_last_gap   = last_gap_q;
		nxt_missing    = missing_q;
		nxt_running    = running_q;
		nxt_status     = sgc_pkg::ST_OK;
		case (item_s1.command)
			sgc_pkg::CMD_CHECK: begin
				if (!running_q) begin
					nxt_status = sgc_pkg::ST_INIT;
				end else if (idx_over) begin
					nxt_status = sgc_pkg::ST_RANGE;
				end else if (idx == last_index_q) begin
					nxt_status   = sgc_pkg::ST_SEQ;
					nxt_last_gap = '0;
				end else begin
					nxt_last_gap   = chk_gap;
					nxt_missing    = chk_miss;
					nxt_last_index = idx;
				end
			end
			sgc_pkg::CMD_INIT: begin
				if (wrap_zero || idx_over) begin
					nxt_status = sgc_pkg::ST_RANGE;
				end else begin
					nxt_last_index = idx;
					nxt_last_gap   = '0;
					nxt_missing    = '0;
					nxt_running    = 1'b1;
				end
			end
			sgc_pkg::CMD_RESET: begin
				if (!running_q) begin
					nxt_status = sgc_pkg::ST_SEQ;
				end else if (wrap_zero || idx_over) begin
					nxt_status = sgc_pkg::ST_RANGE;
				end else begin
					nxt_last_index = idx;
					nxt_last_gap   = '0;
					nxt_missing    = '0;
				end
			end
			sgc_pkg::CMD_DEINIT: begin
				if (!running_q) begin
					nxt_status = sgc_pkg::ST_SEQ;
				end else begin
					nxt_last_index = '0;
					nxt_last_gap   = '0;
					nxt_missing    = '0;
					nxt_running    = 1'b0;
				end
			end
			sgc_pkg::CMD_QUERY: begin
				nxt_status = running_q ? sgc_pkg::ST_OK : sgc_pkg::ST_INIT;
			end
			default: begin
				nxt_status = sgc_pkg::ST_RANGE;
			end
		endcase
	end

	// checker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_index_q <= '0;
			last_gap_q   <= '0;
			missing_q    <= '0;
			running_q    <= 1'b0;
		end else if (advance) begin
			last_index_q <= nxt_last_index;
			last_gap_q   <= nxt_last_gap;
			missing_q    <= nxt_missing;
			running_q    <= nxt_running;
		end
	end

	// result register
	assign nxt_gap_ext = 64'(nxt_last_gap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.status        <= nxt_status;
			result_q.gap           <= (|nxt_gap_ext[63:32]) ? 32'hFFFF_FFFF
			                                                : nxt_gap_ext[31:0];
			result_q.missing_total <= nxt_missing;
			result_q.active        <= nxt_running;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks
	`SGC_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, item_stall, valid_s1)
	`SGC_ASSERT_IMP(a_active_tracks_state, clk, arst_n, result_valid_q,
		result_q.active == running_q)
	`SGC_ASSERT_IMP(a_inactive_is_clear, clk, arst_n, result_valid_q && !result_q.active,
		(result_q.gap == 32'd0) && (result_q.missing_total == 32'd0))
	`SGC_ASSERT_IMP(a_not_init_inactive, clk, arst_n,
		result_valid_q && (result_q.status == sgc_pkg::ST_INIT), !result_q.active)
	`SGC_ASSERT_NXT(a_advance_gives_result, clk, arst_n, advance, result_valid_q)

endmodule
